// File: design/fqs_pkg.sv
// Shared types, constants and helper functions for the queue-with-search block.
package fqs_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned PTR_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned POS_W      = 5;

  typedef enum logic [2:0] {
    FUNC_PUSH  = 3'd0,
    FUNC_POP   = 3'd1,
    FUNC_READ  = 3'd2,
    FUNC_FIND  = 3'd3,
    FUNC_CLEAR = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FAIL = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RDWAIT,
    S_SCAN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]                func;
    logic signed [FIELD_W-1:0] data_value;
    logic [POS_W-1:0]          position;
  } fqs_in_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [FIELD_W-1:0] result_value;
    logic [POS_W-1:0]          found_position;
    logic [POS_W-1:0]          item_count;
    logic                      is_empty;
  } fqs_out_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
  } fqs_stat_t;

  typedef struct packed {
    logic                  we;
    logic [PTR_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [PTR_W-1:0]      raddr;
  } fqs_mem_req_t;

  // Low DATA_WIDTH bits of the 32-bit field, zero-filled when wider.
  function automatic logic [DATA_WIDTH-1:0] to_store(logic [FIELD_W-1:0] v);
    logic [63:0] t;
    t = {32'd0, v};
    return t[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(logic [DATA_WIDTH-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[FIELD_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] cnt_field(logic [CNT_W-1:0] c);
    logic [15:0] t;
    t = 16'(c);
    return t[POS_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_add(logic [PTR_W-1:0] base,
                                                logic [PTR_W-1:0] off);
    logic [PTR_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (PTR_W + 1)'(DEPTH)) begin
      s = s - (PTR_W + 1)'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

// File: design/fqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fqs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/fqs_ctrl.sv
// Request sequencer: ring pointers, entry count and the shared address/compare step.
module fqs_ctrl
  import fqs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  fqs_in_t               req_i,
  input  logic                  out_free_i,
  input  logic [DATA_WIDTH-1:0] rdata_i,
  output fqs_mem_req_t          mem_o,
  output fqs_stat_t             stat_o,
  output fqs_out_t              res_o
);

  state_e                state_q, state_d;
  logic [PTR_W-1:0]      head_q, head_d;
  logic [PTR_W-1:0]      tail_q, tail_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]      idx_q, idx_d;
  fqs_in_t               req_q, req_d;
  status_e               status_q, status_d;
  logic [FIELD_W-1:0]    value_q, value_d;
  logic [POS_W-1:0]      found_q, found_d;

  func_e                 func_w;
  logic                  empty_w;
  logic                  full_w;
  logic                  read_bad_w;
  logic [15:0]           pos_m1_w;
  logic [DATA_WIDTH-1:0] key_w;
  logic [CNT_W-1:0]      idx_p1_w;
  logic                  hit_w;
  logic                  last_w;

  assign func_w     = func_e'(req_q.func);
  assign empty_w    = (count_q == '0);
  assign full_w     = (count_q >= CNT_W'(DEPTH));
  assign read_bad_w = (req_q.position == '0) || (16'(req_q.position) > 16'(count_q));
  assign pos_m1_w   = 16'(req_q.position) - 16'd1;
  assign key_w      = to_store(req_q.data_value);
  assign idx_p1_w   = CNT_W'(idx_q) + 1'b1;
  assign hit_w      = (rdata_i == key_w);
  assign last_w     = (idx_p1_w == count_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (func_w)
          FUNC_POP:  state_d = empty_w    ? S_RESP : S_RDWAIT;
          FUNC_READ: state_d = read_bad_w ? S_RESP : S_RDWAIT;
          FUNC_FIND: state_d = empty_w    ? S_RESP : S_SCAN;
          default:   state_d = S_RESP;
        endcase
      end
      S_RDWAIT: state_d = S_RESP;
      S_SCAN: begin
        if (hit_w || last_w) state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    rd_ptr_d   = rd_ptr_q;
    idx_d      = idx_q;
    req_d      = req_q;
    status_d   = status_q;
    value_d    = value_q;
    found_d    = found_q;
    mem_o      = '0;
    mem_o.raddr = rd_ptr_q;
    mem_o.waddr = tail_q;
    mem_o.wdata = key_w;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d    = req_i;
          status_d = ST_OK;
          value_d  = '0;
          found_d  = '0;
        end
      end
      S_DECODE: begin
        unique case (func_w)
          FUNC_PUSH: begin
            if (full_w) begin
              status_d = ST_FULL;
            end else begin
              mem_o.we = 1'b1;
              tail_d   = ring_next(tail_q);
              count_d  = count_q + 1'b1;
            end
          end
          FUNC_POP: begin
            if (empty_w) begin
              status_d = ST_FAIL;
            end else begin
              mem_o.raddr = head_q;
              head_d      = ring_next(head_q);
              count_d     = count_q - 1'b1;
            end
          end
          FUNC_READ: begin
            if (read_bad_w) begin
              status_d = ST_FAIL;
            end else begin
              mem_o.raddr = ring_add(head_q, pos_m1_w[PTR_W-1:0]);
            end
          end
          FUNC_FIND: begin
            if (empty_w) begin
              status_d = ST_FAIL;
            end else begin
              mem_o.raddr = head_q;
              rd_ptr_d    = head_q;
              idx_d       = '0;
            end
          end
          FUNC_CLEAR: begin
            head_d  = '0;
            tail_d  = '0;
            count_d = '0;
          end
          default: status_d = ST_FAIL;
        endcase
      end
      S_RDWAIT: value_d = to_field(rdata_i);
      S_SCAN: begin
        priority if (hit_w) begin
          found_d = cnt_field(idx_p1_w);
        end else if (last_w) begin
          status_d = ST_FAIL;
        end else begin
          // advance to the next entry; its data returns next cycle
          rd_ptr_d    = ring_next(rd_ptr_q);
          mem_o.raddr = ring_next(rd_ptr_q);
          idx_d       = idx_q + 1'b1;
        end
      end
      S_RESP: ;
      default: ;
    endcase
  end

  always_comb begin
    stat_o.busy      = (state_q != S_IDLE);
    stat_o.res_valid = (state_q == S_RESP) && out_free_i;
    res_o.status         = status_q;
    res_o.result_value   = value_q;
    res_o.found_position = found_q;
    res_o.item_count     = cnt_field(count_q);
    res_o.is_empty       = empty_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q <= rd_ptr_d;
    idx_q    <= idx_d;
    req_q    <= req_d;
    status_q <= status_d;
    value_q  <= value_d;
    found_q  <= found_d;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == CNT_W'(DEPTH)) |-> head_q == tail_q)
    else $error("pointers disagree with empty or full count");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> idx_p1_w <= count_q)
    else $error("scan offset beyond stored entries");

  a_scan_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> $stable(count_q) && $stable(head_q))
    else $error("queue state changed during search");
`endif

endmodule

// File: design/fifo_queue_with_search_unit.sv
// Top level of the bounded FIFO queue with peek and search.
//
// A bounded first-in first-out queue of DEPTH signed values kept in a ring
// in a single RAM. Each accepted item is one request: push, pop, read by
// 1-based position from the front, find the first position holding a value,
// or clear; each yields exactly one result item carrying status, value, found
// position, entry count and an empty flag. The block takes one request at a
// time and holds in_stall_o high until that request's result has been loaded
// into the output register, which can still be waiting on out_stall_i while
// the next request is accepted. Push, clear, refused and failed requests need
// no RAM read; pop and read need one; find compares stored entries from the
// front until the first match or the last entry. The search rate is set by
// the RAM's single read port, one stored entry per cycle through one shared
// comparator. The RAM needs no clearing pass after reset: only entries
// between head and tail are ever used.
module fifo_queue_with_search_unit
  import fqs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  fqs_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output fqs_out_t out_o
);

  fqs_stat_t             stat;
  fqs_mem_req_t          mem_req;
  fqs_out_t              res;
  logic [DATA_WIDTH-1:0] rdata;
  logic                  start;
  logic                  out_free;
  logic                  out_valid_q, out_valid_d;
  fqs_out_t              out_q;

  // Accept only while the sequencer is idle.
  assign in_stall_o = stat.busy;
  assign start      = in_valid_i && !stat.busy;

  // The output register is free when empty or being taken this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  fqs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  fqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_i      (in_i),
    .out_free_i (out_free),
    .rdata_i    (rdata),
    .mem_o      (mem_req),
    .stat_o     (stat),
    .res_o      (res)
  );

  // Load a new result, or drop the held one once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (stat.res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.res_valid |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a held item");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.res_valid |=> !stat.res_valid)
    else $error("two results for one request");

  a_stall_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> in_stall_o)
    else $error("not busy after accepting a request");
`endif

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the bounded FIFO queue with peek and search.
module testbench
  import fqs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 900;
  localparam int CALM_ITEMS   = 100;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 300;
  localparam int REPORT_MAX   = 10;

  // Request codes the block does not define; each must come back as a failure.
  localparam logic [2:0] FUNC_UNUSED_A = 3'd5;
  localparam logic [2:0] FUNC_UNUSED_B = 3'd6;
  localparam logic [2:0] FUNC_UNUSED_C = 3'd7;

  typedef enum int {
    TRAFFIC_FILL,
    TRAFFIC_DRAIN,
    TRAFFIC_BROWSE,
    TRAFFIC_CHURN
  } traffic_e;

  // One row of the directed drill: the request, and a hand-typed result where known.
  typedef struct packed {
    fqs_in_t  req;
    logic     typed;
    fqs_out_t want;
  } drill_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  fqs_in_t  in_i        = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  fqs_out_t out_o;

  // Shadow copy of the queue, advanced once per accepted item.
  logic [DATA_WIDTH-1:0] shadow_ring [DEPTH];
  int                    shadow_head;
  int                    shadow_tail;
  int                    shadow_count;

  fqs_out_t   pending_results [$];
  drill_row_t drill_table [$];
  int         mismatch_count = 0;
  int         sent           = 0;
  int         total_items    = 0;
  int         gap_pct        = 0;
  int         cycle_count    = 0;
  bit         calm           = 1'b0;

  traffic_e traffic;
  int       traffic_left;
  int       overflow_left;

  fifo_queue_with_search_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always #5 clk_i = ~clk_i;

  // Hold reset low at start, then release it on a falling edge.
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Apply one request to the shadow queue and return the result it must produce.
  function automatic fqs_out_t queue_apply(fqs_in_t req);
    fqs_out_t r;
    int       idx;
    r = '0;
    r.status = ST_OK;
    case (req.func)
      FUNC_PUSH: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_ring[shadow_tail] = req.data_value[DATA_WIDTH-1:0];
          shadow_tail = (shadow_tail + 1) % DEPTH;
          shadow_count++;
        end
      end
      FUNC_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_FAIL;
        end else begin
          r.result_value = shadow_ring[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end
      end
      FUNC_READ: begin
        if (req.position == 0 || int'(req.position) > shadow_count) begin
          r.status = ST_FAIL;
        end else begin
          idx = (shadow_head + int'(req.position) - 1) % DEPTH;
          r.result_value = shadow_ring[idx];
        end
      end
      FUNC_FIND: begin
        r.status = ST_FAIL;
        // Walk from the front; stop at the first match.
        for (int i = 0; i < shadow_count; i++) begin
          idx = (shadow_head + i) % DEPTH;
          if (r.status == ST_FAIL && shadow_ring[idx] == req.data_value[DATA_WIDTH-1:0]) begin
            r.status = ST_OK;
            r.found_position = POS_W'(i + 1);
          end
        end
      end
      FUNC_CLEAR: begin
        shadow_head  = 0;
        shadow_tail  = 0;
        shadow_count = 0;
      end
      default: begin
        r.status = ST_FAIL;
      end
    endcase
    r.item_count = POS_W'(shadow_count);
    r.is_empty   = (shadow_count == 0);
    return r;
  endfunction

  // Mix fully random words with a small pool that makes duplicates and extremes common.
  function automatic logic [FIELD_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      4, 5, 6, 7: return FIELD_W'($signed($urandom_range(0, 7)) - 4);
      8:          return {1'b0, {(FIELD_W-1){1'b1}}};
      9:          return {1'b1, {(FIELD_W-1){1'b0}}};
      default:    return $urandom();
    endcase
  endfunction

  // Search mostly for values that are stored, so hits land at every depth.
  function automatic logic [FIELD_W-1:0] find_target();
    if (shadow_count > 0 && $urandom_range(0, 99) < 75) begin
      return shadow_ring[(shadow_head + $urandom_range(0, shadow_count - 1)) % DEPTH];
    end
    return draw_value();
  endfunction

  function automatic logic [POS_W-1:0] read_position();
    if (shadow_count > 0 && $urandom_range(0, 99) < 85) begin
      return POS_W'($urandom_range(1, shadow_count));
    end
    return POS_W'($urandom_range(0, 31));
  endfunction

  function automatic void pick_traffic();
    traffic       = traffic_e'($urandom_range(0, 3));
    traffic_left  = $urandom_range(10, 40);
    overflow_left = $urandom_range(1, 3);
  endfunction

  // Build the next random request from the traffic pattern and the shadow state.
  function automatic fqs_in_t draw_request();
    fqs_in_t req;
    int      roll;
    req.func       = FUNC_PUSH;
    req.data_value = draw_value();
    req.position   = POS_W'($urandom_range(0, 31));
    roll = $urandom_range(0, 99);
    case (traffic)
      TRAFFIC_FILL: begin
        // Push until full, then a few refused pushes, then move on.
        if (shadow_count >= DEPTH) begin
          overflow_left--;
          if (overflow_left <= 0) pick_traffic();
        end
      end
      TRAFFIC_DRAIN: begin
        if (roll < 70) begin
          req.func = FUNC_POP;
          if (shadow_count == 0) begin
            overflow_left--;
            if (overflow_left <= 0) pick_traffic();
          end
        end else if (roll < 85) begin
          req.func     = FUNC_READ;
          req.position = read_position();
        end else begin
          req.func       = FUNC_FIND;
          req.data_value = find_target();
        end
      end
      TRAFFIC_BROWSE: begin
        if (roll < 45) begin
          req.func     = FUNC_READ;
          req.position = read_position();
        end else if (roll < 90) begin
          req.func       = FUNC_FIND;
          req.data_value = find_target();
        end else if (roll < 95) begin
          req.func = FUNC_POP;
        end
        traffic_left--;
        if (traffic_left <= 0) pick_traffic();
      end
      default: begin
        if (roll < 40) begin
          req.func = FUNC_PUSH;
        end else if (roll < 75) begin
          req.func = FUNC_POP;
        end else if (roll < 85) begin
          req.func     = FUNC_READ;
          req.position = read_position();
        end else if (roll < 93) begin
          req.func       = FUNC_FIND;
          req.data_value = find_target();
        end else if (roll < 97) begin
          req.func = FUNC_CLEAR;
        end else begin
          req.func = 3'($urandom_range(FUNC_UNUSED_A, FUNC_UNUSED_C));
        end
        traffic_left--;
        if (traffic_left <= 0) pick_traffic();
      end
    endcase
    return req;
  endfunction

  function automatic drill_row_t plain(logic [2:0] f, logic [FIELD_W-1:0] v, logic [POS_W-1:0] p);
    drill_row_t row;
    row = '0;
    row.req.func       = f;
    row.req.data_value = v;
    row.req.position   = p;
    return row;
  endfunction

  function automatic drill_row_t known(logic [2:0] f, logic [FIELD_W-1:0] v,
                                       logic [POS_W-1:0] p, status_e st,
                                       logic [FIELD_W-1:0] val, logic [POS_W-1:0] fp,
                                       logic [POS_W-1:0] cnt);
    drill_row_t row;
    row = plain(f, v, p);
    row.typed               = 1'b1;
    row.want.status         = st;
    row.want.result_value   = val;
    row.want.found_position = fp;
    row.want.item_count     = cnt;
    row.want.is_empty       = (cnt == 0);
    return row;
  endfunction

  // Offer one item, hold it until accepted, then record what it must produce.
  task automatic send_item(fqs_in_t req, logic typed, fqs_out_t want);
    fqs_out_t predicted;
    if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= req;
    do @(posedge clk_i); while (in_stall_o);
    // Advance the shadow queue even where the expectation is typed by hand.
    predicted = queue_apply(req);
    pending_results.push_back(typed ? want : predicted);
    sent++;
    if (sent >= total_items - CALM_ITEMS) calm = 1'b1;
    @(negedge clk_i);
  endtask

  task automatic note_mismatch(string what, fqs_out_t want, fqs_out_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("mismatch (%s) at cycle %0d: want st=%0d val=%h pos=%0d cnt=%0d emp=%0d",
               what, cycle_count, want.status, want.result_value, want.found_position,
               want.item_count, want.is_empty);
      $display("                          got  st=%0d val=%h pos=%0d cnt=%0d emp=%0d",
               got.status, got.result_value, got.found_position, got.item_count,
               got.is_empty);
    end
  endtask

  // Compare every accepted result with the oldest outstanding expectation.
  always @(posedge clk_i) begin : result_check
    fqs_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        note_mismatch("no item outstanding", '0, out_o);
      end else begin
        want = pending_results.pop_front();
        if (out_o.status !== want.status || out_o.result_value !== want.result_value ||
            out_o.found_position !== want.found_position ||
            out_o.item_count !== want.item_count || out_o.is_empty !== want.is_empty) begin
          note_mismatch("field", want, out_o);
        end
      end
    end
  end

  // Bound the run in case the block stops handshaking.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off to back the block up,
  // and no stalls once the run is winding down.
  initial begin : receiver
    int  hold;
    int  tick;
    int  stall_pct;
    bit  held;
    hold      = 0;
    tick      = 0;
    stall_pct = 20;
    held      = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      tick++;
      if (tick % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 50;
        endcase
      end
      if (!held && sent >= HOLD_AFTER) begin
        out_stall_i <= 1'b1;
        hold = 0;
        while (hold < HOLD_CYCLES) begin
          @(negedge clk_i);
          hold++;
        end
        out_stall_i <= 1'b0;
        held = 1'b1;
      end else if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Sender: directed drill first, then shaped random traffic, then drain and report.
  initial begin : sender
    shadow_head  = 0;
    shadow_tail  = 0;
    shadow_count = 0;
    for (int i = 0; i < DEPTH; i++) shadow_ring[i] = '0;
    traffic       = TRAFFIC_FILL;
    traffic_left  = 0;
    overflow_left = 3;

    // Empty queue: every request that needs an entry fails.
    drill_table.push_back(known(FUNC_POP, '0, 5'd0, ST_FAIL, '0, 5'd0, 5'd0));
    drill_table.push_back(known(FUNC_READ, '0, 5'd1, ST_FAIL, '0, 5'd0, 5'd0));
    drill_table.push_back(known(FUNC_FIND, '0, 5'd0, ST_FAIL, '0, 5'd0, 5'd0));
    // Undefined request codes.
    drill_table.push_back(known(FUNC_UNUSED_A, 32'h0, 5'd0, ST_FAIL, '0, 5'd0, 5'd0));
    drill_table.push_back(known(FUNC_UNUSED_B, 32'h5555_5555, 5'd21, ST_FAIL, '0, 5'd0, 5'd0));
    drill_table.push_back(known(FUNC_UNUSED_C, 32'hFFFF_FFFF, 5'd31, ST_FAIL, '0, 5'd0, 5'd0));
    // Value extremes.
    drill_table.push_back(known(FUNC_PUSH, 32'h7FFF_FFFF, 5'd0, ST_OK, '0, 5'd0, 5'd1));
    drill_table.push_back(known(FUNC_PUSH, 32'h8000_0000, 5'd0, ST_OK, '0, 5'd0, 5'd2));
    drill_table.push_back(known(FUNC_PUSH, 32'hFFFF_FFFF, 5'd0, ST_OK, '0, 5'd0, 5'd3));
    // Position zero, first, last, one past and far past the count.
    drill_table.push_back(known(FUNC_READ, '0, 5'd0, ST_FAIL, '0, 5'd0, 5'd3));
    drill_table.push_back(known(FUNC_READ, '0, 5'd1, ST_OK, 32'h7FFF_FFFF, 5'd0, 5'd3));
    drill_table.push_back(known(FUNC_READ, '0, 5'd3, ST_OK, 32'hFFFF_FFFF, 5'd0, 5'd3));
    drill_table.push_back(known(FUNC_READ, '0, 5'd4, ST_FAIL, '0, 5'd0, 5'd3));
    drill_table.push_back(known(FUNC_READ, '0, 5'd31, ST_FAIL, '0, 5'd0, 5'd3));
    // Find a hit, a miss, and the first of two equal entries.
    drill_table.push_back(known(FUNC_FIND, 32'h8000_0000, 5'd0, ST_OK, '0, 5'd2, 5'd3));
    drill_table.push_back(known(FUNC_FIND, 32'h0, 5'd0, ST_FAIL, '0, 5'd0, 5'd3));
    drill_table.push_back(known(FUNC_PUSH, 32'h8000_0000, 5'd0, ST_OK, '0, 5'd0, 5'd4));
    drill_table.push_back(known(FUNC_FIND, 32'h8000_0000, 5'd0, ST_OK, '0, 5'd2, 5'd4));
    drill_table.push_back(known(FUNC_POP, '0, 5'd0, ST_OK, 32'h7FFF_FFFF, 5'd0, 5'd3));
    drill_table.push_back(known(FUNC_FIND, 32'h8000_0000, 5'd0, ST_OK, '0, 5'd1, 5'd3));
    // Clear from a nonzero head, then reuse the ring.
    drill_table.push_back(known(FUNC_CLEAR, '0, 5'd0, ST_OK, '0, 5'd0, 5'd0));
    drill_table.push_back(known(FUNC_POP, '0, 5'd0, ST_FAIL, '0, 5'd0, 5'd0));
    drill_table.push_back(plain(FUNC_PUSH, 32'h1234_5678, 5'd0));
    drill_table.push_back(plain(FUNC_READ, '0, 5'd1));
    drill_table.push_back(plain(FUNC_CLEAR, '0, 5'd0));

    total_items = drill_table.size() + RANDOM_ITEMS;

    @(posedge rst_ni);
    @(negedge clk_i);
    foreach (drill_table[i]) begin
      send_item(drill_table[i].req, drill_table[i].typed, drill_table[i].want);
    end

    // Random part opens by filling the ring, so a refused push comes early.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          default: gap_pct = 35;
        endcase
      end
      send_item(draw_request(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then let the pipeline settle.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
design/fqs_pkg.sv
design/fqs_ram.sv
design/fqs_ctrl.sv
design/fifo_queue_with_search_unit.sv
bench/testbench.sv
